FILE: src/ntaf_pkg.sv
// ----------------------------------------------------------------------------
// ntaf_pkg - shared definitions for the number-to-ASCII formatter
// Format codes, character constants and the command that starts the
// character serializer.
// ----------------------------------------------------------------------------
package ntaf_pkg;

    localparam int VALUE_W  = 32;
    localparam int BCD_DIGS = 10;
    localparam int BCD_W    = 4 * BCD_DIGS;
    localparam int SH_W     = BCD_W;
    localparam int LEFT_W   = 6;

    // Format selector codes
    localparam logic [1:0] OP_DEC  = 2'd0;
    localparam logic [1:0] OP_HEX  = 2'd1;
    localparam logic [1:0] OP_BIN  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // Accepted binary widths
    localparam logic [7:0] BW_8  = 8'd8;
    localparam logic [7:0] BW_16 = 8'd16;
    localparam logic [7:0] BW_32 = 8'd32;

    // Characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [3:0] NIB_TEN  = 4'd10;

    typedef enum logic [1:0] {
        MODE_DEC,
        MODE_HEX,
        MODE_BIN
    } t_mode;

    typedef struct packed {
        logic               load;
        t_mode              mode;
        logic [SH_W-1:0]    data;
        logic [LEFT_W-1:0]  count;
    } t_ser_cmd;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < NIB_TEN) begin
            c = CH_ZERO + {4'd0, nib};
        end else begin
            c = CH_A + {4'd0, nib - NIB_TEN};
        end
        return c;
    endfunction

endpackage

FILE: src/ntaf_bcd.sv
// ----------------------------------------------------------------------------
// ntaf_bcd - bit-serial binary to BCD converter
// Shifts the binary value in one bit per cycle, correcting each BCD digit
// (add three when five or more) before every shift.
// ----------------------------------------------------------------------------
module ntaf_bcd
    import ntaf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_busy,
    output logic               o_done,
    output logic [BCD_W-1:0]   o_bcd
);

    localparam int CNT_W = $clog2(VALUE_W);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [BCD_W-1:0]   n_bcd;
    logic [BCD_W-1:0]   w_adj;

    // Correct every digit, then shift in the next binary bit
    always_comb begin
        for (int d = 0; d < BCD_DIGS; d++) begin
            if (r_bcd[4*d +: 4] > 4'd4) begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
        n_bcd = {w_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_load && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_bin  <= i_value;
                r_bcd  <= '0;
            end else if (r_busy) begin
                r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
                r_bcd <= n_bcd;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_busy && (r_cnt == CNT_W'(VALUE_W - 1));
    assign o_bcd  = n_bcd;

endmodule

FILE: src/ntaf_ser.sv
// ----------------------------------------------------------------------------
// ntaf_ser - character serializer
// Walks a shift register one nibble or one bit per cycle (paused for prefix
// and spaces) and emits one ASCII character per cycle, bar suppressed zeros.
// ----------------------------------------------------------------------------
module ntaf_ser
    import ntaf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ser_cmd  i_cmd,
    output logic      o_busy,
    output logic      o_strobe,
    output logic [7:0] o_char,
    output logic      o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PFX0,
        S_PFXX,
        S_NIB,
        S_BIT,
        S_SPACE
    } t_state;

    t_state            r_state;
    logic [SH_W-1:0]   r_sh;
    logic [LEFT_W-1:0] r_left;
    logic              r_seen;
    logic              r_strobe;
    logic              r_last;
    logic [7:0]        r_char;
    logic [3:0]        w_nib;
    logic              w_final;

    assign w_nib   = r_sh[SH_W-1 -: 4];
    assign w_final = (r_left == LEFT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.load) begin
                        r_sh   <= i_cmd.data;
                        r_left <= i_cmd.count;
                        r_seen <= 1'b0;
                        unique case (i_cmd.mode)
                            MODE_DEC: r_state <= S_NIB;
                            MODE_HEX: r_state <= S_PFX0;
                            MODE_BIN: r_state <= S_BIT;
                            default:  r_state <= S_IDLE;
                        endcase
                    end
                end
                S_PFX0: begin
                    r_strobe <= 1'b1;
                    r_char   <= CH_ZERO;
                    r_state  <= S_PFXX;
                end
                S_PFXX: begin
                    r_strobe <= 1'b1;
                    r_char   <= CH_X;
                    r_state  <= S_NIB;
                end
                S_NIB: begin
                    // Drop leading zeros, but always show the final digit
                    if (w_nib != 4'd0 || r_seen || w_final) begin
                        r_strobe <= 1'b1;
                        r_char   <= hex_char(w_nib);
                        r_last   <= w_final;
                        r_seen   <= 1'b1;
                    end
                    r_sh   <= {r_sh[SH_W-5:0], 4'd0};
                    r_left <= r_left - 1'b1;
                    if (w_final) begin
                        r_state <= S_IDLE;
                    end
                end
                S_BIT: begin
                    r_strobe <= 1'b1;
                    r_char   <= r_sh[SH_W-1] ? CH_ONE : CH_ZERO;
                    r_last   <= w_final;
                    r_sh     <= {r_sh[SH_W-2:0], 1'b0};
                    r_left   <= r_left - 1'b1;
                    if (w_final) begin
                        r_state <= S_IDLE;
                    end else if (r_left[1:0] == 2'b01) begin
                        r_state <= S_SPACE;
                    end
                end
                S_SPACE: begin
                    r_strobe <= 1'b1;
                    r_char   <= CH_SPACE;
                    r_state  <= S_BIT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_char   = r_char;
    assign o_last   = r_last;

endmodule

FILE: src/number_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// number_to_ascii_formatter_core - number to ASCII text formatter
// Turns a 32-bit unsigned value into decimal, 0x-hex or spaced binary text,
// one character per strobe, with the final character flagged.
// ----------------------------------------------------------------------------
// Order: hex and binary load the serializer straight from the ports; decimal
//   first runs the serial BCD conversion, then one digit slot a cycle.
// Output: one character per cycle once output starts, except for suppressed
//   hex leading zeros after the prefix; start is not taken while busy.
// busy drops as the last character goes out; the receiver cannot stall.
// Reset (synchronous, active low) returns both units to idle, no output.
module number_to_ascii_formatter_core
    import ntaf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_op,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [7:0]         i_bin_width,
    output logic               o_strobe,
    output logic [7:0]         o_char_code,
    output logic               o_last
);

    logic             w_accept;
    logic             w_bin_ok;
    logic             w_bcd_busy;
    logic             w_bcd_done;
    logic [BCD_W-1:0] w_bcd;
    logic             w_ser_busy;
    t_ser_cmd         w_cmd;

    // A transaction is taken whenever start is seen while idle
    assign w_accept = start && !busy;
    assign w_bin_ok = (i_bin_width == BW_8) || (i_bin_width == BW_16) ||
                      (i_bin_width == BW_32);

    ntaf_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept && (i_op == OP_DEC)),
        .i_value (i_value),
        .o_busy  (w_bcd_busy),
        .o_done  (w_bcd_done),
        .o_bcd   (w_bcd)
    );

    // Build the serializer command: decimal comes from the BCD unit when it
    // finishes; hex and binary load straight from the input ports. Binary
    // left-aligns the shown bits at the top of the shift register.
    always_comb begin
        w_cmd = '{load: 1'b0, mode: MODE_DEC, data: w_bcd,
                  count: LEFT_W'(BCD_DIGS)};
        if (w_bcd_done) begin
            w_cmd.load = 1'b1;
        end else if (w_accept) begin
            priority if (i_op == OP_HEX) begin
                w_cmd.load  = 1'b1;
                w_cmd.mode  = MODE_HEX;
                w_cmd.data  = {i_value, 8'd0};
                w_cmd.count = LEFT_W'(VALUE_W / 4);
            end else if (i_op == OP_BIN && w_bin_ok) begin
                w_cmd.load = 1'b1;
                w_cmd.mode = MODE_BIN;
                priority if (i_bin_width == BW_8) begin
                    w_cmd.data  = {i_value[7:0], 32'd0};
                    w_cmd.count = LEFT_W'(8);
                end else if (i_bin_width == BW_16) begin
                    w_cmd.data  = {i_value[15:0], 24'd0};
                    w_cmd.count = LEFT_W'(16);
                end else begin
                    w_cmd.data  = {i_value, 8'd0};
                    w_cmd.count = LEFT_W'(32);
                end
            end else begin
                // Unused format or bad width: drop the transaction
                w_cmd.load = 1'b0;
            end
        end
    end

    ntaf_ser u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_busy   (w_ser_busy),
        .o_strobe (o_strobe),
        .o_char   (o_char_code),
        .o_last   (o_last)
    );

    assign busy = w_bcd_busy || w_ser_busy;

    // A character only follows a busy cycle
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("character emitted without a transaction in flight");

    // last is only flagged on a real character
    a_last_has_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe)
        else $error("last flagged without strobe");

    // The final character frees the block
    a_last_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("still busy after last character");

    // Unused format produces nothing and leaves the block idle
    a_none_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_op == OP_NONE) |=> !busy)
        else $error("unused format started work");

    // Hex always produces output
    a_hex_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_op == OP_HEX) |=> busy)
        else $error("hex transaction not started");

endmodule

FILE: tb/tb_number_to_ascii_formatter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_number_to_ascii_formatter_core - self-checking bench for the formatter
// Drives decimal, hex, binary and silent format commands over the start/busy
// handshake, predicts the ASCII text of each accepted transaction and checks
// every strobed character and its last flag against that prediction.
// ----------------------------------------------------------------------------
module tb_number_to_ascii_formatter_core;
    import ntaf_pkg::*;

    localparam int          CMD_TARGET  = 180;     // random commands that make text
    localparam int unsigned CYCLE_LIMIT = 200000;  // far above the slowest legal run
    localparam int          TAIL_CYCLES = 48;      // worst decimal latency plus margin

    // Uppercase hex digit table, first character in the top byte
    localparam logic [8*16-1:0] HEX_DIGITS = "0123456789ABCDEF";

    typedef struct {
        logic [1:0]         op;
        logic [VALUE_W-1:0] value;
        logic [7:0]         bin_width;
        int unsigned        gap;      // idle cycles before start is raised
        bit                 drain;    // hold start until all text has come back
    } fmt_cmd_t;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    logic [1:0]         i_op        = OP_DEC;
    logic [VALUE_W-1:0] i_value     = '0;
    logic [7:0]         i_bin_width = '0;
    logic               o_strobe;
    logic [7:0]         o_char_code;
    logic               o_last;

    fmt_cmd_t    pending_cmds[$];
    text_char_t  expected_chars[$];

    fmt_cmd_t    active_cmd;
    bit          cmd_loaded   = 1'b0;
    bit          launch;
    int unsigned gap_left     = 0;
    bit          text_drained = 1'b1;
    int unsigned burst_left   = 0;

    int unsigned cycle_cnt    = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned chars_seen   = 0;
    int unsigned dec_cnt      = 0;
    int unsigned hex_cnt      = 0;
    int unsigned bin_cnt      = 0;
    int unsigned silent_cnt   = 0;

    number_to_ascii_formatter_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_value     (i_value),
        .i_bin_width (i_bin_width),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Text predictor: build the full character string for one command and
    // append it to the expected stream, flagging the final character.
    // ------------------------------------------------------------------------
    function automatic void format_expected_text(input logic [1:0] op,
                                                 input logic [VALUE_W-1:0] value,
                                                 input logic [7:0] bin_width);
        logic [7:0]         chars[$];
        logic [VALUE_W-1:0] rest;
        logic [3:0]         nib;
        bit                 seen;
        text_char_t         tc;
        chars = {};
        case (op)
            OP_DEC: begin
                // peel digits off the low end, so build the string backwards
                rest = value;
                do begin
                    chars.push_front(CH_ZERO + 8'(rest % 10));
                    rest = rest / 10;
                end while (rest != 0);
            end
            OP_HEX: begin
                chars.push_back(CH_ZERO);
                chars.push_back(CH_X);
                seen = 1'b0;
                for (int k = 7; k >= 0; k--) begin
                    nib = value[4*k +: 4];
                    if (nib != 0 || seen) begin
                        chars.push_back(HEX_DIGITS[8*(15 - int'(nib)) +: 8]);
                        seen = 1'b1;
                    end
                end
                // an all-zero value still shows one digit
                if (!seen) begin
                    chars.push_back(CH_ZERO);
                end
            end
            OP_BIN: begin
                // only three widths are legal; anything else stays silent
                if (bin_width == BW_8 || bin_width == BW_16 || bin_width == BW_32) begin
                    for (int p = int'(bin_width) - 1; p >= 0; p--) begin
                        chars.push_back(value[p] ? CH_ONE : CH_ZERO);
                        if (p != 0 && p % 4 == 0) begin
                            chars.push_back(CH_SPACE);
                        end
                    end
                end
            end
            default: begin
                // unused format: no text at all
            end
        endcase
        foreach (chars[i]) begin
            tc.code = chars[i];
            tc.last = (i == chars.size() - 1);
            expected_chars.push_back(tc);
        end
    endfunction

    function automatic bit makes_text(input logic [1:0] op, input logic [7:0] bin_width);
        if (op == OP_DEC || op == OP_HEX) begin
            return 1'b1;
        end
        return op == OP_BIN &&
               (bin_width == BW_8 || bin_width == BW_16 || bin_width == BW_32);
    endfunction

    task automatic queue_cmd(input logic [1:0] op, input logic [VALUE_W-1:0] value,
                             input logic [7:0] bin_width, input bit drain);
        fmt_cmd_t c;
        c.op        = op;
        c.value     = value;
        c.bin_width = bin_width;
        c.drain     = drain;
        // leave some runs with no idle cycles at all between commands
        if (burst_left != 0) begin
            c.gap = 0;
            burst_left--;
        end else begin
            c.gap = $urandom_range(0, 4);
        end
        pending_cmds.push_back(c);
    endtask

    task automatic note_mismatch(input string what, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("[%0t] mismatch on %s: expected 0x%02h, got 0x%02h",
                     $realtime, what, exp_v, act_v);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: raise start for the next queued command after its idle gap and
    // hold it until the handshake completes. Predict text at acceptance.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            launch = start;
            if (start && !busy) begin
                format_expected_text(active_cmd.op, active_cmd.value, active_cmd.bin_width);
                if (!makes_text(active_cmd.op, active_cmd.bin_width)) begin
                    silent_cnt++;
                end else if (active_cmd.op == OP_DEC) begin
                    dec_cnt++;
                end else if (active_cmd.op == OP_HEX) begin
                    hex_cnt++;
                end else begin
                    bin_cnt++;
                end
                cmd_loaded = 1'b0;
                launch     = 1'b0;
            end
            if (!launch) begin
                if (!cmd_loaded && pending_cmds.size() != 0) begin
                    active_cmd = pending_cmds.pop_front();
                    gap_left   = active_cmd.gap;
                    // let the drain flag see the latest prediction before start is raised
                    if (active_cmd.drain && gap_left == 0) begin
                        gap_left = 1;
                    end
                    cmd_loaded = 1'b1;
                end
                if (cmd_loaded) begin
                    if (gap_left != 0) begin
                        gap_left--;
                    end else if (!active_cmd.drain || text_drained) begin
                        launch      = 1'b1;
                        i_op        <= active_cmd.op;
                        i_value     <= active_cmd.value;
                        i_bin_width <= active_cmd.bin_width;
                    end
                end
            end
            start <= launch;
        end
    end

    // Sample the empty state away from the active edge so the driver never
    // races the monitor's pop.
    always @(negedge i_clk) begin
        text_drained <= (expected_chars.size() == 0);
    end

    // ------------------------------------------------------------------------
    // Monitor: every strobe is one character; match it against the oldest
    // expected character, field by field.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        text_char_t exp_c;
        if (i_rst_n && o_strobe) begin
            chars_seen++;
            if (expected_chars.size() == 0) begin
                note_mismatch("unexpected character", 8'h00, o_char_code);
            end else begin
                exp_c = expected_chars.pop_front();
                if (o_char_code !== exp_c.code) begin
                    note_mismatch("char_code", exp_c.code, o_char_code);
                end
                if (o_last !== exp_c.last) begin
                    note_mismatch("last", {7'd0, exp_c.last}, {7'd0, o_last});
                end
            end
        end
    end

    // Watchdog: a hung handshake or a missing character ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d characters still expected",
                     cycle_cnt, expected_chars.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------------
    initial begin
        int          made;
        int          pick;
        logic [1:0]          op;
        logic [VALUE_W-1:0]  value;
        logic [7:0]          width;

        // Directed: field extremes, every format, the silent cases
        queue_cmd(OP_DEC, 32'd0,          8'd0,   1'b0);
        queue_cmd(OP_DEC, 32'hFFFF_FFFF,  8'd255, 1'b0);  // width ignored
        queue_cmd(OP_DEC, 32'd9,          8'd0,   1'b0);
        queue_cmd(OP_DEC, 32'd10,         8'd8,   1'b0);
        queue_cmd(OP_DEC, 32'd1000000000, 8'd0,   1'b0);
        queue_cmd(OP_HEX, 32'd0,          8'd0,   1'b0);
        queue_cmd(OP_HEX, 32'hFFFF_FFFF,  8'd16,  1'b0);
        queue_cmd(OP_HEX, 32'h8000_0000,  8'd255, 1'b0);
        queue_cmd(OP_HEX, 32'h0000_A0F0,  8'd0,   1'b0);
        queue_cmd(OP_HEX, 32'd1,          8'd32,  1'b0);
        queue_cmd(OP_BIN, 32'h0000_00A5,  BW_8,   1'b0);
        queue_cmd(OP_BIN, 32'hFFFF_FF00,  BW_8,   1'b0);  // upper bits hidden
        queue_cmd(OP_BIN, 32'h0000_1234,  BW_16,  1'b0);
        queue_cmd(OP_BIN, 32'hFFFF_FFFF,  BW_32,  1'b0);
        queue_cmd(OP_BIN, 32'd0,          BW_32,  1'b1);  // let everything drain
        queue_cmd(OP_BIN, 32'h5A5A_5A5A,  8'd0,   1'b0);  // bad widths: silent
        queue_cmd(OP_BIN, 32'h5A5A_5A5A,  8'd7,   1'b0);
        queue_cmd(OP_BIN, 32'h5A5A_5A5A,  8'd33,  1'b0);
        queue_cmd(OP_BIN, 32'h5A5A_5A5A,  8'd255, 1'b0);
        queue_cmd(OP_NONE, 32'hFFFF_FFFF, BW_32,  1'b0);  // unused format
        queue_cmd(OP_NONE, 32'd0,         8'd0,   1'b0);
        queue_cmd(OP_DEC, 32'd4294967294, 8'd0,   1'b0);

        // Random: mostly text-making commands, a few silent ones mixed in
        made = 0;
        while (made < CMD_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                op = OP_DEC;
            end else if (pick < 60) begin
                op = OP_HEX;
            end else if (pick < 95) begin
                op = OP_BIN;
            end else begin
                op = OP_NONE;
            end
            if (op == OP_BIN && $urandom_range(0, 99) < 88) begin
                pick = $urandom_range(0, 2);
                width = (pick == 0) ? BW_8 : (pick == 1) ? BW_16 : BW_32;
            end else begin
                width = 8'($urandom_range(0, 255));
            end
            // vary the magnitude so leading-zero suppression gets a workout
            case ($urandom_range(0, 3))
                0:       value = $urandom;
                1:       value = $urandom >> $urandom_range(0, 31);
                2:       value = $urandom_range(0, 20);
                default: value = 32'hFFFF_FFFF >> $urandom_range(0, 31);
            endcase
            if (made % 40 == 5) begin
                burst_left = 15;
            end
            queue_cmd(op, value, width, (made % 60 == 30));
            if (makes_text(op, width)) begin
                made++;
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Hold until every command has been taken, then until all text is back
        while (pending_cmds.size() != 0 || cmd_loaded || start) begin
            @(posedge i_clk);
        end
        while (expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d decimal, %0d hex, %0d binary and %0d silent commands",
                 dec_cnt, hex_cnt, bin_cnt, silent_cnt);
        $display("checked %0d characters, %0d mismatches", chars_seen, mismatch_cnt);
        if (mismatch_cnt == 0 && expected_chars.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
